/* rtl/wsdf_pkg.sv */
`default_nettype none

package wsdf_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int PHASE_W = 3;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 2;
    localparam int KEYS    = 4;

    // Command queue between parser and output stage
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Header constants
    localparam logic [BYTE_W-1:0] CLOSE_BYTE = 8'h88;
    localparam logic [6:0]        LEN_EXT16  = 7'd126;
    localparam logic [6:0]        LEN_EXT64  = 7'd127;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = 2'd3;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_DATA  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_EMPTY = 3'd1;
    localparam logic [EVENT_W-1:0] EV_CLOSE = 3'd2;
    localparam logic [EVENT_W-1:0] EV_DROP  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LINK  = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              link_down;
    } rx_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last;
    } ev_item_t;

    // One classified command: event, raw byte, key byte to apply, last flag
    typedef struct packed {
        logic [EVENT_W-1:0] op;
        logic [BYTE_W-1:0]  raw;
        logic [BYTE_W-1:0]  key;
        logic               last;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/wsdf_front.sv */
`default_nettype none

// Header parser: walk the frame header, capture length and mask key,
// and turn every byte that produces a result into a command.
module wsdf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rx_valid,
    output logic                   rx_ready,
    input  wire wsdf_pkg::rx_item_t rx_item,
    output logic                   cmd_push,
    output wsdf_pkg::cmd_t         cmd,
    input  wire logic              q_full
);

    localparam logic [wsdf_pkg::PHASE_W-1:0] PH_HDR0    = 3'd0;
    localparam logic [wsdf_pkg::PHASE_W-1:0] PH_HDR1    = 3'd1;
    localparam logic [wsdf_pkg::PHASE_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [wsdf_pkg::PHASE_W-1:0] PH_LEN_LO  = 3'd3;
    localparam logic [wsdf_pkg::PHASE_W-1:0] PH_MASK    = 3'd4;
    localparam logic [wsdf_pkg::PHASE_W-1:0] PH_PAYLOAD = 3'd5;

    logic [wsdf_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [wsdf_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [wsdf_pkg::BYTE_W-1:0]  key_reg  [wsdf_pkg::KEYS];
    logic [wsdf_pkg::BYTE_W-1:0]  key_next [wsdf_pkg::KEYS];
    logic [wsdf_pkg::LEN_W-1:0]   count_reg, count_next;
    logic [wsdf_pkg::SLOT_W-1:0]  slot_reg, slot_next;

    logic                         accept;
    logic [wsdf_pkg::BYTE_W-1:0]  b;
    logic [6:0]                   len7;
    logic [wsdf_pkg::LEN_W-1:0]   count_inc;
    logic                         fin;

    assign rx_ready  = !q_full;
    assign accept    = rx_valid && rx_ready;
    assign b         = rx_item.rx_byte;
    assign len7      = b[6:0];
    assign count_inc = count_reg + wsdf_pkg::LEN_W'(1);
    assign fin       = (count_inc == len_reg);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        cmd_push   = 1'b0;
        cmd        = '0;

        if (accept)
        begin
            if (rx_item.link_down)
            begin
                // Link lost: back to reset state
                phase_next = PH_HDR0;
                len_next   = '0;
                for (int i = 0; i < wsdf_pkg::KEYS; i++)
                begin
                    key_next[i] = '0;
                end
                count_next = '0;
                slot_next  = '0;
                cmd_push   = 1'b1;
                cmd.op     = wsdf_pkg::EV_LINK;
                cmd.last   = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR0:
                    begin
                        if (b == wsdf_pkg::CLOSE_BYTE)
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = wsdf_pkg::EV_CLOSE;
                            cmd.last = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HDR1;
                        end
                    end
                    PH_HDR1:
                    begin
                        if (len7 == wsdf_pkg::LEN_EXT16)
                        begin
                            phase_next = PH_LEN_HI;
                        end
                        else if (len7 == wsdf_pkg::LEN_EXT64)
                        begin
                            phase_next = PH_HDR0;
                            cmd_push   = 1'b1;
                            cmd.op     = wsdf_pkg::EV_DROP;
                            cmd.last   = 1'b1;
                        end
                        else
                        begin
                            len_next   = wsdf_pkg::LEN_W'(len7);
                            slot_next  = '0;
                            phase_next = PH_MASK;
                        end
                    end
                    PH_LEN_HI:
                    begin
                        len_next   = {b, 8'h00};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        len_next   = {len_reg[15:8], b};
                        slot_next  = '0;
                        phase_next = PH_MASK;
                    end
                    PH_MASK:
                    begin
                        key_next[slot_reg] = b;
                        if (slot_reg != wsdf_pkg::LAST_SLOT)
                        begin
                            slot_next = slot_reg + wsdf_pkg::SLOT_W'(1);
                        end
                        else
                        begin
                            slot_next  = '0;
                            count_next = '0;
                            if (len_reg == '0)
                            begin
                                phase_next = PH_HDR0;
                                cmd_push   = 1'b1;
                                cmd.op     = wsdf_pkg::EV_EMPTY;
                                cmd.last   = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        cmd_push = 1'b1;
                        cmd.op   = wsdf_pkg::EV_DATA;
                        cmd.raw  = b;
                        cmd.key  = key_reg[count_reg[wsdf_pkg::SLOT_W-1:0]];
                        cmd.last = fin;
                        if (fin)
                        begin
                            phase_next = PH_HDR0;
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HDR0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            len_reg   <= '0;
            for (int i = 0; i < wsdf_pkg::KEYS; i++)
            begin
                key_reg[i] <= '0;
            end
            count_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/wsdf_queue.sv */
`default_nettype none

// Two-entry command queue between parser and output stage.
module wsdf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire wsdf_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output wsdf_pkg::cmd_t      head,
    output logic                not_empty
);

    wsdf_pkg::cmd_t                entry_reg [wsdf_pkg::QDEPTH];
    logic [wsdf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wsdf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wsdf_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == wsdf_pkg::QCNT_W'(wsdf_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + wsdf_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + wsdf_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + wsdf_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - wsdf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/wsdf_back.sv */
`default_nettype none

// Output stage: unmask the payload byte and hold the result until taken.
module wsdf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_not_empty,
    input  wire wsdf_pkg::cmd_t q_head,
    output logic                q_pop,
    output logic                ev_valid,
    input  wire logic           ev_ready,
    output wsdf_pkg::ev_item_t  ev_item
);

    logic               valid_reg;
    wsdf_pkg::ev_item_t item_reg, item_next;

    // Advance when the output slot is free or being emptied
    assign q_pop = q_not_empty && (!valid_reg || ev_ready);

    always_comb
    begin
        item_next.event_res    = q_head.op;
        item_next.payload_byte = q_head.raw ^ q_head.key;
        item_next.last         = q_head.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (ev_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= item_next;
        end
    end

    assign ev_valid = valid_reg;
    assign ev_item  = item_reg;

endmodule

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
`default_nettype none

// Path: the result of a taken byte is written into the command queue at the accepting edge,
// and the output register then loads it from the queue head when the output slot is free.
// Throughput: one byte per cycle; rx_ready drops only when the two-entry command
// queue is full, which happens only while the result side stalls.
// Reset: rst_n clears parser state, mask key, queue pointers and output valid at once.
module websocket_frame_deframer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_ready,
    input  wire wsdf_pkg::rx_item_t rx_item,
    output logic                    ev_valid,
    input  wire logic               ev_ready,
    output wsdf_pkg::ev_item_t      ev_item
);

    // Commands from parser into the queue
    logic           cmd_push;
    wsdf_pkg::cmd_t cmd;
    logic           q_full;

    // Queue head toward the output stage
    logic           q_pop;
    wsdf_pkg::cmd_t q_head;
    logic           q_not_empty;

    // Front: parse headers, capture the mask key, classify each byte.
    // Bytes that produce no result push nothing: length bytes and most header and mask bytes.
    wsdf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_item  (rx_item),
        .cmd_push (cmd_push),
        .cmd      (cmd),
        .q_full   (q_full)
    );

    // Decouple the parser from output stalls
    wsdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // Back: unmask the payload byte and hold the item in the output register
    wsdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .ev_valid    (ev_valid),
        .ev_ready    (ev_ready),
        .ev_item     (ev_item)
    );

endmodule

`default_nettype wire
